>>> rtl/bq_pkg.sv
// Shared types, constants and saturation helpers for the biquad section.
// Used by every module of the block; no dependencies of its own.
package bq_pkg;

    localparam int SAMPLE_W   = 24;
    localparam int COEF_W     = 32;
    localparam int GUARD_BITS = 8;
    localparam int HIST_W     = SAMPLE_W + GUARD_BITS;
    localparam int COEF_FRAC  = COEF_W - 4;
    localparam int PROD_W     = COEF_W + HIST_W;
    localparam int TERM_W     = PROD_W - COEF_FRAC;
    localparam int ACC_W      = TERM_W + 4;
    localparam int CFG_IDX_W  = 3;

    // half an LSB of the history format, in product scaling
    localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(1) << (COEF_FRAC - 1);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] IDX_FORM_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] IDX_COEF_A0   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] IDX_COEF_A1   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] IDX_COEF_A2   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] IDX_COEF_B1   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] IDX_COEF_B2   = 3'd5;

    typedef enum logic [1:0] {
        FORM_DIRECT,
        FORM_CANON,
        FORM_TDIRECT,
        FORM_TCANON
    } form_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        C_A0,
        C_A1,
        C_A2,
        C_B1,
        C_B2
    } coef_sel_t;

    typedef enum logic [2:0] {
        OP_X,
        OP_IN1,
        OP_IN2,
        OP_OUT1,
        OP_OUT2,
        OP_W,
        OP_YS
    } opnd_sel_t;

    typedef enum logic [2:0] {
        BASE_ZERO,
        BASE_X,
        BASE_IN1,
        BASE_IN2,
        BASE_OUT2,
        BASE_XOUT1
    } base_sel_t;

    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_LOAD_ADD,
        ACC_LOAD_SUB,
        ACC_ADD,
        ACC_SUB,
        ACC_BASE
    } acc_op_t;

    typedef struct packed {
        logic [COEF_W-1:0] a0;
        logic [COEF_W-1:0] a1;
        logic [COEF_W-1:0] a2;
        logic [COEF_W-1:0] b1;
        logic [COEF_W-1:0] b2;
    } bq_coef_t;

    // controller to datapath
    typedef struct packed {
        logic      load_x;
        logic      push_out;
        coef_sel_t coef_sel;
        opnd_sel_t opnd_sel;
        acc_op_t   acc_op;
        base_sel_t base_sel;
        logic      wr_w;
        logic      wr_ys;
        logic      wr_in1;
        logic      wr_in2;
        logic      wr_out1;
        logic      wr_out2;
        logic      shift_dir;
        logic      shift_can;
    } bq_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;
    } bq_stat_t;

    function automatic logic signed [HIST_W-1:0] sat_hist(input logic signed [ACC_W-1:0] v);
        logic [ACC_W-HIST_W:0] top;
        top = v[ACC_W-1:HIST_W-1];
        if ((&top) || !(|top))
            return v[HIST_W-1:0];
        else if (v[ACC_W-1])
            return {1'b1, {(HIST_W-1){1'b0}}};
        else
            return {1'b0, {(HIST_W-1){1'b1}}};
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] sat_samp(input logic signed [ACC_W-1:0] v);
        logic [ACC_W-SAMPLE_W:0] top;
        top = v[ACC_W-1:SAMPLE_W-1];
        if ((&top) || !(|top))
            return v[SAMPLE_W-1:0];
        else if (v[ACC_W-1])
            return {1'b1, {(SAMPLE_W-1){1'b0}}};
        else
            return {1'b0, {(SAMPLE_W-1){1'b1}}};
    endfunction

endpackage

>>> rtl/biquad_iir_filter.sv
// One word is sequenced at a time: a new word is accepted only once the previous one
// has finished its steps, as every product goes through the single shared 32x32
// multiplier and its product register feeding the adder.
// Reset (rst_n low, async) clears the four history registers and the handshake
// state, and loads the registers with direct form, a0 = 1.0, other gains zero.
// Top level of the second-order IIR section; depends on bq_pkg, bq_regs, bq_dp, bq_ctrl.
module biquad_iir_filter (
    input  logic                                 clk,
    input  logic                                 rst_n,

    // configuration write port
    input  logic                                 cfg_we,
    input  logic [bq_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [bq_pkg::COEF_W-1:0]            cfg_data,

    // input word channel
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [bq_pkg::SAMPLE_W-1:0]   sample_in,

    // output word channel
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [bq_pkg::SAMPLE_W-1:0]   sample_out
);

    // Samples Q1.23, coefficients Q4.28, history Q9.23 with eight guard bits.
    // Each product is rounded half up to 23 fraction bits; sums are exact in a
    // 40-bit accumulator, then saturated to history or sample range on store.

    bq_pkg::form_t    form_mode;
    bq_pkg::bq_coef_t coef;
    bq_pkg::bq_cmd_t  cmd;
    bq_pkg::bq_stat_t stat;

    bq_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .form_mode (form_mode),
        .coef      (coef)
    );

    // Sequencer: at most one multiply issued per step, accumulated the step after.
    bq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .form_mode (form_mode),
        .stat      (stat),
        .in_stall  (in_stall),
        .cmd       (cmd)
    );

    // Datapath with the output register, so a new word can enter while the
    // previous result still waits downstream.
    bq_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .coef       (coef),
        .sample_in  (sample_in),
        .out_stall  (out_stall),
        .stat       (stat),
        .out_valid  (out_valid),
        .sample_out (sample_out)
    );

endmodule

>>> rtl/bq_regs.sv
// Configuration register bank: form select and the five coefficients.
// Depends on bq_pkg.
module bq_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [bq_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [bq_pkg::COEF_W-1:0]           cfg_data,
    output bq_pkg::form_t                       form_mode,
    output bq_pkg::bq_coef_t                    coef
);

    bq_pkg::form_t    form_mode_reg;
    bq_pkg::bq_coef_t coef_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            form_mode_reg <= bq_pkg::FORM_DIRECT;
            coef_reg.a0   <= bq_pkg::COEF_W'(1) << bq_pkg::COEF_FRAC;   // unity gain
            coef_reg.a1   <= '0;
            coef_reg.a2   <= '0;
            coef_reg.b1   <= '0;
            coef_reg.b2   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bq_pkg::IDX_FORM_MODE: form_mode_reg <= bq_pkg::form_t'(cfg_data[1:0]);
                bq_pkg::IDX_COEF_A0:   coef_reg.a0   <= cfg_data;
                bq_pkg::IDX_COEF_A1:   coef_reg.a1   <= cfg_data;
                bq_pkg::IDX_COEF_A2:   coef_reg.a2   <= cfg_data;
                bq_pkg::IDX_COEF_B1:   coef_reg.b1   <= cfg_data;
                bq_pkg::IDX_COEF_B2:   coef_reg.b2   <= cfg_data;
                default:               ;   // unmapped index, ignored
            endcase
        end
    end

    assign form_mode = form_mode_reg;
    assign coef      = coef_reg;

endmodule

>>> rtl/bq_dp.sv
// Datapath: history registers, shared multiplier, rounding accumulator and
// output word register. Driven step by step by bq_ctrl. Depends on bq_pkg.
module bq_dp (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  bq_pkg::bq_cmd_t                      cmd,
    input  bq_pkg::bq_coef_t                     coef,
    input  logic signed [bq_pkg::SAMPLE_W-1:0]   sample_in,
    input  logic                                 out_stall,
    output bq_pkg::bq_stat_t                     stat,
    output logic                                 out_valid,
    output logic signed [bq_pkg::SAMPLE_W-1:0]   sample_out
);

    localparam int SW = bq_pkg::SAMPLE_W;
    localparam int HW = bq_pkg::HIST_W;
    localparam int CW = bq_pkg::COEF_W;
    localparam int PW = bq_pkg::PROD_W;
    localparam int TW = bq_pkg::TERM_W;
    localparam int AW = bq_pkg::ACC_W;

    // history (state, cleared by reset)
    logic signed [HW-1:0] hist_in1_reg,  hist_in1_next;
    logic signed [HW-1:0] hist_in2_reg,  hist_in2_next;
    logic signed [HW-1:0] hist_out1_reg, hist_out1_next;
    logic signed [HW-1:0] hist_out2_reg, hist_out2_next;

    // working payload
    logic signed [SW-1:0] x_reg;
    logic signed [HW-1:0] w_reg;
    logic signed [SW-1:0] ys_reg;
    logic signed [PW-1:0] prod_reg, prod_next;
    logic signed [AW-1:0] acc_reg,  acc_next;

    logic                 out_valid_reg;
    logic signed [SW-1:0] sample_out_reg;

    logic signed [CW-1:0] coef_mux;
    logic signed [HW-1:0] opnd_mux;
    logic signed [AW-1:0] base_mux;
    logic signed [PW-1:0] rnd;
    logic signed [TW-1:0] term;
    logic signed [AW-1:0] term_ext;
    logic signed [HW-1:0] acc_sat_h;
    logic signed [SW-1:0] acc_sat_s;

    // multiplier operands and accumulator base
    always_comb
    begin
        case (cmd.coef_sel)
            bq_pkg::C_A0: coef_mux = coef.a0;
            bq_pkg::C_A1: coef_mux = coef.a1;
            bq_pkg::C_A2: coef_mux = coef.a2;
            bq_pkg::C_B1: coef_mux = coef.b1;
            bq_pkg::C_B2: coef_mux = coef.b2;
            default:      coef_mux = '0;
        endcase

        case (cmd.opnd_sel)
            bq_pkg::OP_X:    opnd_mux = HW'(x_reg);
            bq_pkg::OP_IN1:  opnd_mux = hist_in1_reg;
            bq_pkg::OP_IN2:  opnd_mux = hist_in2_reg;
            bq_pkg::OP_OUT1: opnd_mux = hist_out1_reg;
            bq_pkg::OP_OUT2: opnd_mux = hist_out2_reg;
            bq_pkg::OP_W:    opnd_mux = w_reg;
            bq_pkg::OP_YS:   opnd_mux = HW'(ys_reg);
            default:         opnd_mux = '0;
        endcase

        case (cmd.base_sel)
            bq_pkg::BASE_X:     base_mux = AW'(x_reg);
            bq_pkg::BASE_IN1:   base_mux = AW'(hist_in1_reg);
            bq_pkg::BASE_IN2:   base_mux = AW'(hist_in2_reg);
            bq_pkg::BASE_OUT2:  base_mux = AW'(hist_out2_reg);
            bq_pkg::BASE_XOUT1: base_mux = AW'(x_reg) + AW'(hist_out1_reg);
            default:            base_mux = '0;
        endcase
    end

    // 32x32 signed product, registered before rounding
    assign prod_next = coef_mux * opnd_mux;

    // round half up to history format: add half LSB, arithmetic shift
    assign rnd      = prod_reg + bq_pkg::RND_HALF;
    assign term     = rnd[PW-1:bq_pkg::COEF_FRAC];
    assign term_ext = AW'(term);

    always_comb
    begin
        case (cmd.acc_op)
            bq_pkg::ACC_LOAD_ADD: acc_next = base_mux + term_ext;
            bq_pkg::ACC_LOAD_SUB: acc_next = base_mux - term_ext;
            bq_pkg::ACC_ADD:      acc_next = acc_reg + term_ext;
            bq_pkg::ACC_SUB:      acc_next = acc_reg - term_ext;
            bq_pkg::ACC_BASE:     acc_next = base_mux;
            default:              acc_next = acc_reg;
        endcase
    end

    assign acc_sat_h = bq_pkg::sat_hist(acc_reg);
    assign acc_sat_s = bq_pkg::sat_samp(acc_reg);

    // history update
    always_comb
    begin
        hist_in1_next  = hist_in1_reg;
        hist_in2_next  = hist_in2_reg;
        hist_out1_next = hist_out1_reg;
        hist_out2_next = hist_out2_reg;
        if (cmd.shift_dir)
        begin
            hist_in2_next  = hist_in1_reg;
            hist_in1_next  = HW'(x_reg);
            hist_out2_next = hist_out1_reg;
            hist_out1_next = HW'(acc_sat_s);
        end
        if (cmd.shift_can)
        begin
            hist_in2_next = hist_in1_reg;
            hist_in1_next = w_reg;
        end
        if (cmd.wr_in1)
            hist_in1_next = acc_sat_h;
        if (cmd.wr_in2)
            hist_in2_next = acc_sat_h;
        if (cmd.wr_out1)
            hist_out1_next = acc_sat_h;
        if (cmd.wr_out2)
            hist_out2_next = acc_sat_h;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_in1_reg  <= '0;
            hist_in2_reg  <= '0;
            hist_out1_reg <= '0;
            hist_out2_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            hist_in1_reg  <= hist_in1_next;
            hist_in2_reg  <= hist_in2_next;
            hist_out1_reg <= hist_out1_next;
            hist_out2_reg <= hist_out2_next;
            if (cmd.push_out)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        if (cmd.load_x)
            x_reg <= sample_in;
        if (cmd.wr_w)
            w_reg <= acc_sat_h;
        if (cmd.wr_ys || cmd.shift_dir)
            ys_reg <= acc_sat_s;
        if (cmd.push_out)
            sample_out_reg <= ys_reg;
    end

    assign stat.out_free = !out_valid_reg || !out_stall;
    assign out_valid     = out_valid_reg;
    assign sample_out    = sample_out_reg;

endmodule

>>> rtl/bq_ctrl.sv
// Sequencer: walks the micro-steps of the selected form and hands the
// finished word to the output register. Depends on bq_pkg.
module bq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  bq_pkg::form_t     form_mode,
    input  bq_pkg::bq_stat_t  stat,
    output logic              in_stall,
    output bq_pkg::bq_cmd_t   cmd
);

    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] LAST_DIRECT  = 4'd6;
    localparam logic [STEP_W-1:0] LAST_CANON   = 4'd8;
    localparam logic [STEP_W-1:0] LAST_TDIRECT = 4'd8;
    localparam logic [STEP_W-1:0] LAST_TCANON  = 4'd7;

    bq_pkg::state_t    state_reg, state_next;
    logic [STEP_W-1:0] step_reg,  step_next;
    logic [STEP_W-1:0] last_step;
    logic              accept;

    always_comb
    begin
        unique case (form_mode)
            bq_pkg::FORM_DIRECT:  last_step = LAST_DIRECT;
            bq_pkg::FORM_CANON:   last_step = LAST_CANON;
            bq_pkg::FORM_TDIRECT: last_step = LAST_TDIRECT;
            bq_pkg::FORM_TCANON:  last_step = LAST_TCANON;
            default:              last_step = LAST_DIRECT;
        endcase
    end

    // new word taken when idle, or while the finished one moves out
    assign in_stall = !((state_reg == bq_pkg::ST_IDLE) ||
                        (state_reg == bq_pkg::ST_DONE && stat.out_free));
    assign accept   = in_valid && !in_stall;

    // next state
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            bq_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = bq_pkg::ST_RUN;
                    step_next  = '0;
                end
            end
            bq_pkg::ST_RUN:
            begin
                if (step_reg == last_step)
                    state_next = bq_pkg::ST_DONE;
                else
                    step_next = step_reg + 1'b1;
            end
            bq_pkg::ST_DONE:
            begin
                if (accept)
                begin
                    state_next = bq_pkg::ST_RUN;
                    step_next  = '0;
                end
                else if (stat.out_free)
                    state_next = bq_pkg::ST_IDLE;
            end
            default:
                state_next = bq_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bq_pkg::ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // step commands; acc ops act on the product issued in the previous step
    always_comb
    begin
        cmd          = '0;
        cmd.load_x   = accept;
        cmd.push_out = (state_reg == bq_pkg::ST_DONE) && stat.out_free;
        if (state_reg == bq_pkg::ST_RUN)
        begin
            unique case (form_mode)
                bq_pkg::FORM_DIRECT:
                begin
                    case (step_reg)
                        4'd0: begin cmd.coef_sel = bq_pkg::C_A0; cmd.opnd_sel = bq_pkg::OP_X; end
                        4'd1:
                        begin
                            cmd.coef_sel = bq_pkg::C_A1; cmd.opnd_sel = bq_pkg::OP_IN1;
                            cmd.acc_op   = bq_pkg::ACC_LOAD_ADD;
                            cmd.base_sel = bq_pkg::BASE_ZERO;
                        end
                        4'd2:
                        begin
                            cmd.coef_sel = bq_pkg::C_A2; cmd.opnd_sel = bq_pkg::OP_IN2;
                            cmd.acc_op   = bq_pkg::ACC_ADD;
                        end
                        4'd3:
                        begin
                            cmd.coef_sel = bq_pkg::C_B1; cmd.opnd_sel = bq_pkg::OP_OUT1;
                            cmd.acc_op   = bq_pkg::ACC_ADD;
                        end
                        4'd4:
                        begin
                            cmd.coef_sel = bq_pkg::C_B2; cmd.opnd_sel = bq_pkg::OP_OUT2;
                            cmd.acc_op   = bq_pkg::ACC_SUB;
                        end
                        4'd5: cmd.acc_op = bq_pkg::ACC_SUB;
                        4'd6: cmd.shift_dir = 1'b1;
                        default: ;
                    endcase
                end
                bq_pkg::FORM_CANON:
                begin
                    case (step_reg)
                        4'd0: begin cmd.coef_sel = bq_pkg::C_B1; cmd.opnd_sel = bq_pkg::OP_IN1; end
                        4'd1:
                        begin
                            cmd.coef_sel = bq_pkg::C_B2; cmd.opnd_sel = bq_pkg::OP_IN2;
                            cmd.acc_op   = bq_pkg::ACC_LOAD_SUB;
                            cmd.base_sel = bq_pkg::BASE_X;
                        end
                        4'd2: cmd.acc_op = bq_pkg::ACC_SUB;
                        4'd3: cmd.wr_w   = 1'b1;
                        4'd4: begin cmd.coef_sel = bq_pkg::C_A0; cmd.opnd_sel = bq_pkg::OP_W; end
                        4'd5:
                        begin
                            cmd.coef_sel = bq_pkg::C_A1; cmd.opnd_sel = bq_pkg::OP_IN1;
                            cmd.acc_op   = bq_pkg::ACC_LOAD_ADD;
                            cmd.base_sel = bq_pkg::BASE_ZERO;
                        end
                        4'd6:
                        begin
                            cmd.coef_sel = bq_pkg::C_A2; cmd.opnd_sel = bq_pkg::OP_IN2;
                            cmd.acc_op   = bq_pkg::ACC_ADD;
                        end
                        4'd7: cmd.acc_op = bq_pkg::ACC_ADD;
                        4'd8: begin cmd.wr_ys = 1'b1; cmd.shift_can = 1'b1; end
                        default: ;
                    endcase
                end
                bq_pkg::FORM_TDIRECT:
                begin
                    case (step_reg)
                        4'd0: begin cmd.acc_op = bq_pkg::ACC_BASE; cmd.base_sel = bq_pkg::BASE_XOUT1; end
                        4'd1: cmd.wr_w = 1'b1;
                        4'd2: begin cmd.coef_sel = bq_pkg::C_A0; cmd.opnd_sel = bq_pkg::OP_W; end
                        4'd3:
                        begin
                            cmd.coef_sel = bq_pkg::C_B1; cmd.opnd_sel = bq_pkg::OP_W;
                            cmd.acc_op   = bq_pkg::ACC_LOAD_ADD;
                            cmd.base_sel = bq_pkg::BASE_IN1;
                        end
                        4'd4:
                        begin
                            cmd.coef_sel = bq_pkg::C_B2; cmd.opnd_sel = bq_pkg::OP_W;
                            cmd.wr_ys    = 1'b1;
                            cmd.acc_op   = bq_pkg::ACC_LOAD_SUB;
                            cmd.base_sel = bq_pkg::BASE_OUT2;
                        end
                        4'd5:
                        begin
                            cmd.coef_sel = bq_pkg::C_A1; cmd.opnd_sel = bq_pkg::OP_W;
                            cmd.wr_out1  = 1'b1;
                            cmd.acc_op   = bq_pkg::ACC_LOAD_SUB;
                            cmd.base_sel = bq_pkg::BASE_ZERO;
                        end
                        4'd6:
                        begin
                            cmd.coef_sel = bq_pkg::C_A2; cmd.opnd_sel = bq_pkg::OP_W;
                            cmd.wr_out2  = 1'b1;
                            cmd.acc_op   = bq_pkg::ACC_LOAD_ADD;
                            cmd.base_sel = bq_pkg::BASE_IN2;
                        end
                        4'd7:
                        begin
                            cmd.wr_in1   = 1'b1;
                            cmd.acc_op   = bq_pkg::ACC_LOAD_ADD;
                            cmd.base_sel = bq_pkg::BASE_ZERO;
                        end
                        4'd8: cmd.wr_in2 = 1'b1;
                        default: ;
                    endcase
                end
                bq_pkg::FORM_TCANON:
                begin
                    case (step_reg)
                        4'd0: begin cmd.coef_sel = bq_pkg::C_A0; cmd.opnd_sel = bq_pkg::OP_X; end
                        4'd1: begin cmd.acc_op = bq_pkg::ACC_LOAD_ADD; cmd.base_sel = bq_pkg::BASE_IN1; end
                        4'd2:
                        begin
                            cmd.wr_ys    = 1'b1;
                            cmd.coef_sel = bq_pkg::C_A1; cmd.opnd_sel = bq_pkg::OP_X;
                        end
                        4'd3:
                        begin
                            cmd.coef_sel = bq_pkg::C_B1; cmd.opnd_sel = bq_pkg::OP_YS;
                            cmd.acc_op   = bq_pkg::ACC_LOAD_ADD;
                            cmd.base_sel = bq_pkg::BASE_IN2;
                        end
                        4'd4:
                        begin
                            cmd.coef_sel = bq_pkg::C_A2; cmd.opnd_sel = bq_pkg::OP_X;
                            cmd.acc_op   = bq_pkg::ACC_SUB;
                        end
                        4'd5:
                        begin
                            cmd.coef_sel = bq_pkg::C_B2; cmd.opnd_sel = bq_pkg::OP_YS;
                            cmd.wr_in1   = 1'b1;
                            cmd.acc_op   = bq_pkg::ACC_LOAD_ADD;
                            cmd.base_sel = bq_pkg::BASE_ZERO;
                        end
                        4'd6: cmd.acc_op = bq_pkg::ACC_SUB;
                        4'd7: cmd.wr_in2 = 1'b1;
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end

    // an accepted word always starts at the first step
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == bq_pkg::ST_RUN) && (step_reg == '0))
        else $error("bq_ctrl: accepted word did not start its sequence");

    // the step counter never runs past the last step of the form
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bq_pkg::ST_RUN) |-> (step_reg <= last_step))
        else $error("bq_ctrl: step counter beyond last step");

    // a finished word waits while the output register is full and stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bq_pkg::ST_DONE) && !stat.out_free |=> (state_reg == bq_pkg::ST_DONE))
        else $error("bq_ctrl: finished word dropped while output stalled");

    // no word is taken while a sequence is in progress
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bq_pkg::ST_RUN) |-> in_stall)
        else $error("bq_ctrl: input taken mid-sequence");

endmodule
